// ----- src/additive_harmonic_synth_defines.svh -----
// Assertion macros for the additive harmonic synthesizer.
// A file that uses them must have clk_i and rst_ni in scope.
`ifndef ADDITIVE_HARMONIC_SYNTH_DEFINES_SVH
`define ADDITIVE_HARMONIC_SYNTH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ahs: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ahs: assertion failed");

`endif

// ----- src/ahs_pkg.sv -----
// Shared types and constants of the additive harmonic synthesizer.
// Used by every module of the block but ahs_ram; depends on nothing.
`default_nettype none

package ahs_pkg;

  localparam int FRAME_LENGTH     = 2048;
  localparam int FRAME_BITS       = $clog2(FRAME_LENGTH);
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_BITS        = $clog2(SINE_TABLE_DEPTH);
  localparam int TBL_ENTRIES      = SINE_TABLE_DEPTH + 1;
  localparam int TBL_AW           = SINE_BITS + 1;

  localparam int SINE_W  = 15;
  localparam int AMP_W   = 16;
  localparam int PHASE_W = 16;
  localparam int INDEX_W = 11;
  localparam int VALUE_W = 22;
  localparam int HN_W    = 7;

  // The per-harmonic step h*i*65536/FRAME_LENGTH lands on these bit positions.
  localparam int ANGLE_SHIFT = PHASE_W - FRAME_BITS;
  // Table index is the top two quadrant bits plus SINE_BITS offset bits.
  localparam int LUT_SHIFT   = PHASE_W - 2 - SINE_BITS;

  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam int          TAYLOR_TERMS = 9;

  localparam int OUT_MAX = 2097151;
  localparam int OUT_MIN = -2097152;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } ahs_op_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } ahs_state_e;

  typedef enum logic [2:0] {
    IS_X,
    IS_SQ,
    IS_MUL,
    IS_DIV,
    IS_ACC,
    IS_WR,
    IS_DONE
  } ahs_init_state_e;

  typedef struct packed {
    logic [AMP_W-1:0]   amp;
    logic [PHASE_W-1:0] phase;
  } ahs_entry_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] addr;
    logic [SINE_W-1:0] data;
  } ahs_tbl_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ahs_seq_status_t;

endpackage

`default_nettype wire

// ----- src/ahs_ram.sv -----
// Generic single-port RAM with registered read data.
// Holds the harmonic store and the quarter-wave sine table; no dependencies.
`default_nettype none

module ahs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/ahs_sine_init.sv -----
// Sine table builder: fills the quarter-wave table after reset with a Q30
// Taylor series, one shared 32x32 multiplier and a bit-serial divider.
// Depends on ahs_pkg.
`default_nettype none

module ahs_sine_init (
  input  logic                clk_i,
  input  logic                rst_ni,
  output ahs_pkg::ahs_tbl_wr_t tbl_wr_o,
  output logic                done_o
);

  import ahs_pkg::*;

  localparam int PKW  = 32 + TBL_AW + 1;
  localparam int DIVW = 33;
  localparam int CW   = 9;
  localparam int BCW  = $clog2(DIVW);

  function automatic logic [CW-1:0] taylor_div(input logic [3:0] n);
    logic [4:0] two;
    two = {n, 1'b0};
    return CW'(10'(two) * 10'(two + 5'd1));
  endfunction

  ahs_init_state_e state_q, state_d;

  logic [TBL_AW-1:0] k_q;
  logic [PKW-1:0]    pk_q;
  logic [31:0]       x_q;
  logic [31:0]       x2_q;
  logic [31:0]       term_q;
  logic signed [33:0] acc_q;
  logic [3:0]        n_q;
  logic [DIVW-1:0]   dq_q;
  logic [CW-1:0]     rem_q;
  logic [BCW-1:0]    bit_q;

  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  mul_p;
  logic [CW-1:0] divisor;
  logic [CW:0]  trial;
  logic         fits;
  logic         last_step;
  logic         last_term;
  logic         last_entry;
  logic [33:0]  acc_u;
  logic [33:0]  acc_rnd;
  logic [18:0]  rounded;

  assign divisor    = taylor_div(n_q);
  assign trial      = {rem_q, dq_q[DIVW-1]};
  assign fits       = trial >= {1'b0, divisor};
  assign last_step  = bit_q == BCW'(DIVW - 1);
  assign last_term  = n_q == 4'(TAYLOR_TERMS);
  assign last_entry = k_q == TBL_AW'(SINE_TABLE_DEPTH);
  assign mul_p      = mul_a * mul_b;

  // Clamp negative sums to zero, then round Q30 down to Q15.
  assign acc_u   = acc_q[33] ? '0 : acc_q;
  assign acc_rnd = acc_u + 34'd16384;
  assign rounded = acc_rnd[33:15];

  always_comb begin
    state_d = state_q;
    case (state_q)
      IS_X:   state_d = IS_SQ;
      IS_SQ:  state_d = IS_MUL;
      IS_MUL: state_d = IS_DIV;
      IS_DIV: begin
        if (last_step) begin
          state_d = IS_ACC;
        end
      end
      IS_ACC: state_d = last_term ? IS_WR : IS_MUL;
      IS_WR:  state_d = last_entry ? IS_DONE : IS_X;
      IS_DONE: state_d = IS_DONE;
      default: state_d = IS_X;
    endcase
  end

  always_comb begin
    tbl_wr_o.we   = 1'b0;
    tbl_wr_o.addr = k_q;
    tbl_wr_o.data = (rounded > 19'd32767) ? {SINE_W{1'b1}} : rounded[SINE_W-1:0];
    done_o        = 1'b0;
    mul_a         = term_q;
    mul_b         = x2_q;
    case (state_q)
      IS_SQ: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      IS_WR:   tbl_wr_o.we = 1'b1;
      IS_DONE: done_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IS_X;
      k_q     <= '0;
      pk_q    <= '0;
      n_q     <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        IS_X: begin
          x_q <= 32'((pk_q + PKW'(SINE_TABLE_DEPTH)) >> (SINE_BITS + 1));
        end
        IS_SQ: begin
          x2_q   <= mul_p[61:30];
          term_q <= x_q;
          acc_q  <= $signed({2'b00, x_q});
          n_q    <= 4'd1;
        end
        IS_MUL: begin
          dq_q  <= mul_p[62:30];
          rem_q <= '0;
          bit_q <= '0;
        end
        IS_DIV: begin
          dq_q  <= {dq_q[DIVW-2:0], fits};
          rem_q <= fits ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
          bit_q <= bit_q + 1'b1;
        end
        IS_ACC: begin
          term_q <= dq_q[31:0];
          // Odd terms of the series subtract, even terms add.
          if (n_q[0]) begin
            acc_q <= acc_q - $signed({2'b00, dq_q[31:0]});
          end else begin
            acc_q <= acc_q + $signed({2'b00, dq_q[31:0]});
          end
          n_q <= n_q + 4'd1;
        end
        IS_WR: begin
          k_q  <= k_q + 1'b1;
          pk_q <= pk_q + PKW'(PI_Q30);
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/ahs_seq.sv -----
// Harmonic sequencer: walks the harmonic store, looks up each sine and runs
// one shared multiply-accumulate per harmonic. Depends on ahs_pkg.
`default_nettype none

module ahs_seq #(
  parameter int HARMONIC_COUNT = 64,
  localparam int HA = (HARMONIC_COUNT > 1) ? $clog2(HARMONIC_COUNT) : 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [ahs_pkg::INDEX_W-1:0]           sample_index_i,
  output logic [HA-1:0]                         store_addr_o,
  input  ahs_pkg::ahs_entry_t                   store_rdata_i,
  input  logic                                  store_hit_i,
  output logic [ahs_pkg::TBL_AW-1:0]            sine_addr_o,
  input  logic [ahs_pkg::SINE_W-1:0]            sine_rdata_i,
  output ahs_pkg::ahs_seq_status_t              status_o,
  output logic signed [ahs_pkg::VALUE_W-1:0]    sample_value_o,
  output logic [ahs_pkg::INDEX_W-1:0]           sample_position_o
);

  import ahs_pkg::*;

  localparam int AW = (32 + HA > 38) ? 32 + HA : 38;
  localparam int SW = AW - 15;

  logic                  run_q;
  logic [HA-1:0]         cnt_q;
  logic [FRAME_BITS-1:0] stp_q;
  logic [INDEX_W-1:0]    idx_q;

  logic                  s1_v_q;
  logic                  s1_last_q;
  logic [FRAME_BITS-1:0] s1_stp_q;

  logic                  s2_v_q;
  logic                  s2_last_q;
  logic                  s2_neg_q;
  logic signed [AMP_W-1:0] s2_amp_q;

  logic                  s3_v_q;
  logic                  s3_last_q;
  logic signed [31:0]    s3_prod_q;

  logic signed [AW-1:0]  acc_q;
  logic                  done_q;

  logic                  issue_last;
  logic [PHASE_W-1:0]    angle;
  logic [SINE_BITS+1:0]  lut_idx;
  logic [SINE_BITS-1:0]  lut_off;
  logic [1:0]            lut_quad;
  logic signed [SINE_W:0] sine_s;
  logic signed [31:0]    prod;
  logic signed [SW-1:0]  shifted;

  assign issue_last   = cnt_q == HA'(HARMONIC_COUNT - 1);
  assign store_addr_o = cnt_q;

  // Angle of harmonic h is (h*i mod FRAME_LENGTH) scaled to a 16-bit turn,
  // plus its stored phase. An entry never loaded since reset has zero phase.
  assign angle    = PHASE_W'({s1_stp_q, {ANGLE_SHIFT{1'b0}}}) +
                    (store_hit_i ? store_rdata_i.phase : PHASE_W'(0));
  assign lut_idx  = angle[PHASE_W-1:LUT_SHIFT];
  assign lut_off  = lut_idx[SINE_BITS-1:0];
  assign lut_quad = lut_idx[SINE_BITS+1:SINE_BITS];
  assign sine_addr_o = lut_quad[0] ? TBL_AW'(SINE_TABLE_DEPTH) - TBL_AW'(lut_off)
                                   : TBL_AW'(lut_off);

  assign sine_s = s2_neg_q ? -$signed({1'b0, sine_rdata_i}) : $signed({1'b0, sine_rdata_i});
  assign prod   = s2_amp_q * sine_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      cnt_q     <= '0;
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      s2_v_q    <= 1'b0;
      s2_last_q <= 1'b0;
      s3_v_q    <= 1'b0;
      s3_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (issue_last) begin
          run_q <= 1'b0;
        end
      end
      s1_v_q    <= run_q;
      s1_last_q <= run_q && issue_last;
      s2_v_q    <= s1_v_q;
      s2_last_q <= s1_last_q;
      s3_v_q    <= s2_v_q;
      s3_last_q <= s2_last_q;
      done_q    <= s3_v_q && s3_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      stp_q <= FRAME_BITS'(sample_index_i);
      idx_q <= sample_index_i;
      acc_q <= '0;
    end else begin
      if (run_q) begin
        stp_q <= stp_q + FRAME_BITS'(idx_q);
      end
      if (s3_v_q) begin
        acc_q <= acc_q + {{(AW-32){s3_prod_q[31]}}, s3_prod_q};
      end
    end
    s1_stp_q  <= stp_q;
    // An entry never loaded since reset counts as zero amplitude.
    s2_amp_q  <= store_hit_i ? $signed(store_rdata_i.amp) : '0;
    s2_neg_q  <= lut_quad[1];
    s3_prod_q <= prod;
  end

  assign shifted = acc_q[AW-1:15];

  always_comb begin
    if (shifted > $signed(SW'(OUT_MAX))) begin
      sample_value_o = VALUE_W'(OUT_MAX);
    end else if (shifted < $signed(SW'(OUT_MIN))) begin
      sample_value_o = VALUE_W'(OUT_MIN);
    end else begin
      sample_value_o = shifted[VALUE_W-1:0];
    end
  end

  assign sample_position_o = idx_q;
  assign status_o.busy     = run_q | s1_v_q | s2_v_q | s3_v_q;
  assign status_o.done     = done_q;

endmodule

`default_nettype wire

// ----- src/additive_harmonic_synth.sv -----
// Compute item: the result is valid after one pass of the shared multiply-accumulate
// per harmonic plus the read and multiply stages, and is held back while the output
// register is stalled; the input is ready again in the cycle the result appears, so
// a new item is taken only once the last result is in the output register. A load leaves the input ready.
// After reset the sine table builder fills the table and in_stall_o stays high until
// the cycle after it is done; the harmonic store reads as all zeros until loaded.
`default_nettype none

`include "additive_harmonic_synth_defines.svh"

module additive_harmonic_synth #(
  parameter int HARMONIC_COUNT = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic [ahs_pkg::HN_W-1:0]            harmonic_number_i,
  input  logic signed [ahs_pkg::AMP_W-1:0]    amplitude_i,
  input  logic [ahs_pkg::PHASE_W-1:0]         phase_offset_i,
  input  logic [ahs_pkg::INDEX_W-1:0]         sample_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ahs_pkg::VALUE_W-1:0]  sample_value_o,
  output logic [ahs_pkg::INDEX_W-1:0]         sample_position_o
);

  import ahs_pkg::*;

  localparam int HA = (HARMONIC_COUNT > 1) ? $clog2(HARMONIC_COUNT) : 1;

  ahs_state_e state_q, state_d;

  ahs_tbl_wr_t     tbl_wr;
  logic            init_done;
  ahs_seq_status_t seq_stat;
  logic            seq_start;
  logic [HA-1:0]   seq_store_addr;
  logic [TBL_AW-1:0] seq_sine_addr;
  logic signed [VALUE_W-1:0] seq_value;
  logic [INDEX_W-1:0] seq_position;

  ahs_entry_t      load_entry;
  ahs_entry_t      store_rdata;
  logic            load_ok;
  logic            load_we;
  logic [HA-1:0]   load_addr;
  logic [HA-1:0]   store_addr;
  logic [HARMONIC_COUNT-1:0] store_vld_q;
  logic            store_hit_q;

  logic [TBL_AW-1:0] sine_addr;
  logic [SINE_W-1:0] sine_rdata;

  logic            out_free;
  logic            out_load;
  logic            out_vld_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic [INDEX_W-1:0] out_pos_q;

  assign load_ok = (operation_i == OP_LOAD) && (harmonic_number_i != '0) &&
                   (int'(harmonic_number_i) <= HARMONIC_COUNT);
  assign load_addr        = HA'(harmonic_number_i - 1'b1);
  assign load_entry.amp   = amplitude_i;
  assign load_entry.phase = phase_offset_i;
  assign out_free         = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (init_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && operation_i == OP_COMPUTE) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (seq_stat.done) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    seq_start  = 1'b0;
    load_we    = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        seq_start  = in_valid_i && operation_i == OP_COMPUTE;
        load_we    = in_valid_i && load_ok;
      end
      ST_RUN:  out_load = seq_stat.done && out_free;
      // The finished sum waits in the sequencer until the output register frees.
      ST_HOLD: out_load = out_free;
      default: ;
    endcase
  end

  assign store_addr = (state_q == ST_RUN) ? seq_store_addr : load_addr;
  assign sine_addr  = (state_q == ST_INIT) ? tbl_wr.addr : seq_sine_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      store_vld_q <= '0;
      store_hit_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      store_hit_q <= store_vld_q[store_addr];
      if (load_we) begin
        store_vld_q[load_addr] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= seq_value;
      out_pos_q   <= seq_position;
    end
  end

  ahs_ram #(
    .WIDTH($bits(ahs_entry_t)),
    .DEPTH(HARMONIC_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .addr_i (store_addr),
    .wdata_i(load_entry),
    .rdata_o(store_rdata)
  );

  ahs_ram #(
    .WIDTH(SINE_W),
    .DEPTH(TBL_ENTRIES)
  ) u_sine_tbl (
    .clk_i  (clk_i),
    .we_i   (tbl_wr.we),
    .addr_i (sine_addr),
    .wdata_i(tbl_wr.data),
    .rdata_o(sine_rdata)
  );

  ahs_sine_init u_sine_init (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tbl_wr_o(tbl_wr),
    .done_o  (init_done)
  );

  ahs_seq #(
    .HARMONIC_COUNT(HARMONIC_COUNT)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (seq_start),
    .sample_index_i   (sample_index_i),
    .store_addr_o     (seq_store_addr),
    .store_rdata_i    (store_rdata),
    .store_hit_i      (store_hit_q),
    .sine_addr_o      (seq_sine_addr),
    .sine_rdata_i     (sine_rdata),
    .status_o         (seq_stat),
    .sample_value_o   (seq_value),
    .sample_position_o(seq_position)
  );

  assign out_valid_o       = out_vld_q;
  assign sample_value_o    = out_value_q;
  assign sample_position_o = out_pos_q;

  `AHS_ASSERT_IMP(a_done_only_in_run, seq_stat.done, state_q == ST_RUN)
  `AHS_ASSERT_IMP(a_tbl_write_in_init, tbl_wr.we, state_q == ST_INIT)
  `AHS_ASSERT_IMP(a_start_when_free, seq_start, !seq_stat.busy && !seq_stat.done)
  `AHS_ASSERT_NXT(a_start_makes_busy, seq_start, seq_stat.busy)

endmodule

`default_nettype wire
